// ===== rtl/rwct_pkg.sv =====
// Shared widths, register indexes and region codes of the wall column texel core.
`default_nettype none

package rwct_pkg;

  localparam int COLUMN_W = 11;
  localparam int ROW_W    = 10;
  localparam int SLICE_W  = 16;
  localparam int COORD_W  = 32;
  localparam int DIR_W    = 18;
  localparam int CFG_W    = 11;
  localparam int RGB_W    = 24;
  localparam int TEXEL_W  = 10;
  localparam int FRAC_W   = 16;
  localparam int DVD_W    = SLICE_W + CFG_W;
  localparam int DIV_BITS = CFG_W;

  localparam int REG_INDEX_W = 3;
  localparam int REG_DATA_W  = RGB_W;

  localparam logic [CFG_W-1:0] SCREEN_HEIGHT_RESET  = 11'd480;
  localparam logic [CFG_W-1:0] TEXTURE_WIDTH_RESET  = 11'd64;
  localparam logic [CFG_W-1:0] TEXTURE_HEIGHT_RESET = 11'd64;
  localparam logic [TEXEL_W-1:0] TEXEL_MAX = '1;

  typedef enum logic [REG_INDEX_W-1:0] {
    REG_SCREEN_HEIGHT  = 3'd0,
    REG_TEXTURE_WIDTH  = 3'd1,
    REG_TEXTURE_HEIGHT = 3'd2,
    REG_CEILING_RGB    = 3'd3,
    REG_FLOOR_RGB      = 3'd4
  } reg_index_t;

  typedef enum logic [1:0] {
    REGION_CEILING = 2'd0,
    REGION_WALL    = 2'd1,
    REGION_FLOOR   = 2'd2,
    REGION_BLANK   = 2'd3
  } region_t;

endpackage

`default_nettype wire

// ===== rtl/rwct_pixel_if.sv =====
// Input channel of the wall column texel core: one screen pixel of a wall column per word.
`default_nettype none

interface rwct_pixel_if
  import rwct_pkg::*;
();

  logic                      valid;
  logic                      ready;
  logic [COLUMN_W-1:0]       column;
  logic [ROW_W-1:0]          row;
  logic [SLICE_W-1:0]        slice_height;
  logic [COORD_W-1:0]        player_coord;
  logic [COORD_W-1:0]        perp_dist;
  logic signed [DIR_W-1:0]   ray_dir;
  logic                      hit_side;
  logic                      side_dir_negative;

  modport source (
    output valid, column, row, slice_height, player_coord, perp_dist, ray_dir,
           hit_side, side_dir_negative,
    input  ready
  );

  modport sink (
    input  valid, column, row, slice_height, player_coord, perp_dist, ray_dir,
           hit_side, side_dir_negative,
    output ready
  );

endinterface

`default_nettype wire

// ===== rtl/rwct_texel_if.sv =====
// Output channel of the wall column texel core: region, fill color and texel coordinates.
`default_nettype none

interface rwct_texel_if
  import rwct_pkg::*;
();

  logic                valid;
  logic                ready;
  logic [COLUMN_W-1:0] out_column;
  logic [ROW_W-1:0]    out_row;
  logic [1:0]          region;
  logic [RGB_W-1:0]    fill_rgb;
  logic [TEXEL_W-1:0]  texel_x;
  logic [TEXEL_W-1:0]  texel_y;

  modport source (
    output valid, out_column, out_row, region, fill_rgb, texel_x, texel_y,
    input  ready
  );

  modport sink (
    input  valid, out_column, out_row, region, fill_rgb, texel_x, texel_y,
    output ready
  );

endinterface

`default_nettype wire

// ===== rtl/raycast_wall_column_texel_core.sv =====
// Top level of the wall column texel core: span classification and texel pipeline.
//
// Each word on the pixel channel is one screen pixel of a raycast wall column.
// The core classes the row as ceiling, wall, floor or blank and, for wall rows,
// returns the texture column and row; ceiling and floor rows carry the colors
// held in the configuration registers. Registers are written through wr_en,
// wr_index and wr_data; the user must do so only while no pixel is in flight,
// as the block does not enforce it. Every pixel gives exactly one word on the
// texel channel, in order. The stages are one for the span compare and the
// distance times direction product, one for the hit fraction and the texel
// row dividend, 11 stages of the texel row divider (one quotient bit each) and
// the output register; a new pixel is taken each cycle unless all stages stall.
// Each stage holds its word while the stage after it is full and stalled, so a
// stall on the texel channel fills the empty stages first and only then
// deasserts ready on the pixel channel. Nothing is dropped or repeated.
// Reset empties the pipeline and loads the registers with their defaults:
// 480 rows, a 64 by 64 texture, black ceiling and floor.
`default_nettype none

module raycast_wall_column_texel_core
  import rwct_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   wr_en,
  input  wire logic [REG_INDEX_W-1:0] wr_index,
  input  wire logic [REG_DATA_W-1:0]  wr_data,
  rwct_pixel_if.sink                  pixel,
  rwct_texel_if.source                texel
);

  localparam int NST = DIV_BITS + 3;
  localparam int ST_A = 0;
  localparam int ST_B = 1;
  localparam int ST_D = 2;
  localparam int ST_O = NST - 1;

  typedef struct packed {
    logic [COLUMN_W-1:0] column;
    logic [ROW_W-1:0]    row;
    region_t             region;
    logic                mirror;
    logic [SLICE_W-1:0]  lh;
    logic [SLICE_W-1:0]  num;
    logic [FRAC_W-1:0]   coord_lo;
    logic [FRAC_W-1:0]   prod_mid;
  } a_t;

  typedef struct packed {
    logic [COLUMN_W-1:0] column;
    logic [ROW_W-1:0]    row;
    region_t             region;
    logic                mirror;
    logic [SLICE_W-1:0]  lh;
    logic [FRAC_W-1:0]   frac;
    logic [DVD_W-1:0]    dvd;
  } b_t;

  typedef struct packed {
    logic [COLUMN_W-1:0] column;
    logic [ROW_W-1:0]    row;
    region_t             region;
    logic                mirror;
    logic [SLICE_W-1:0]  lh;
    logic [FRAC_W-1:0]   frac;
    logic [DVD_W-1:0]    rem;
    logic [DIV_BITS-1:0] quo;
    logic [CFG_W-1:0]    tx;
  } d_t;

  typedef struct packed {
    logic [COLUMN_W-1:0] column;
    logic [ROW_W-1:0]    row;
    region_t             region;
    logic [RGB_W-1:0]    fill;
    logic [TEXEL_W-1:0]  tx;
    logic [TEXEL_W-1:0]  ty;
  } o_t;

  function automatic logic [TEXEL_W-1:0] sat_texel(input logic [CFG_W-1:0] x);
    logic [TEXEL_W-1:0] r;
    r = (x > CFG_W'(TEXEL_MAX)) ? TEXEL_MAX : x[TEXEL_W-1:0];
    return r;
  endfunction

  logic [CFG_W-1:0] screen_height;
  logic [CFG_W-1:0] texture_width;
  logic [CFG_W-1:0] texture_height;
  logic [RGB_W-1:0] ceiling_rgb;
  logic [RGB_W-1:0] floor_rgb;

  logic [NST-1:0] v;
  logic [NST-1:0] en;

  a_t a, a_next;
  b_t b, b_next;
  d_t dst [DIV_BITS];
  d_t dsrc [DIV_BITS];
  d_t dst_next [DIV_BITS];
  o_t o, o_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_height  <= SCREEN_HEIGHT_RESET;
      texture_width  <= TEXTURE_WIDTH_RESET;
      texture_height <= TEXTURE_HEIGHT_RESET;
      ceiling_rgb    <= '0;
      floor_rgb      <= '0;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_SCREEN_HEIGHT:  screen_height  <= wr_data[CFG_W-1:0];
        REG_TEXTURE_WIDTH:  texture_width  <= wr_data[CFG_W-1:0];
        REG_TEXTURE_HEIGHT: texture_height <= wr_data[CFG_W-1:0];
        REG_CEILING_RGB:    ceiling_rgb    <= wr_data[RGB_W-1:0];
        REG_FLOOR_RGB:      floor_rgb      <= wr_data[RGB_W-1:0];
        default: ;
      endcase
    end
  end

  // A stage may load when the texel channel is ready, when it is empty or when some later stage has room.
  always_comb begin
    for (int k = 0; k < NST; k++) begin
      en[k] = texel.ready || (((~v) >> k) != '0);
    end
  end

  assign pixel.ready = en[ST_A];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) begin
        v[0] <= pixel.valid;
      end
      for (int k = 1; k < NST; k++) begin
        if (en[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  // Span classification and fraction product.
  logic [CFG_W-2:0]          half_h;
  logic [SLICE_W-2:0]        lh_half;
  logic [ROW_W-1:0]          span_start;
  logic [SLICE_W-1:0]        end_sum;
  logic [SLICE_W-1:0]        span_end;
  logic signed [COORD_W+DIR_W:0] prod_full;

  assign prod_full = $signed({1'b0, pixel.perp_dist}) * pixel.ray_dir;

  always_comb begin
    half_h  = screen_height[CFG_W-1:1];
    lh_half = pixel.slice_height[SLICE_W-1:1];
    if (SLICE_W'(half_h) >= SLICE_W'(lh_half)) begin
      span_start = ROW_W'(SLICE_W'(half_h) - SLICE_W'(lh_half));
    end else begin
      span_start = '0;
    end
    end_sum = SLICE_W'(lh_half) + SLICE_W'(half_h);
    if (end_sum >= SLICE_W'(screen_height)) begin
      span_end = SLICE_W'(screen_height) - SLICE_W'(1);
    end else begin
      span_end = end_sum;
    end

    a_next.column = pixel.column;
    a_next.row    = pixel.row;
    if (CFG_W'(pixel.row) >= screen_height) begin
      a_next.region = REGION_BLANK;
    end else if (pixel.row < span_start) begin
      a_next.region = REGION_CEILING;
    end else if (SLICE_W'(pixel.row) < span_end) begin
      a_next.region = REGION_WALL;
    end else begin
      a_next.region = REGION_FLOOR;
    end
    a_next.mirror   = pixel.hit_side ~^ pixel.side_dir_negative;
    a_next.lh       = pixel.slice_height;
    a_next.num      = SLICE_W'(pixel.row) + SLICE_W'(lh_half) - SLICE_W'(half_h);
    a_next.coord_lo = pixel.player_coord[FRAC_W-1:0];
    a_next.prod_mid = prod_full[2*FRAC_W-1:FRAC_W];
  end

  // Hit fraction and texel row dividend.
  always_comb begin
    b_next.column = a.column;
    b_next.row    = a.row;
    b_next.region = a.region;
    b_next.mirror = a.mirror;
    b_next.lh     = a.lh;
    b_next.frac   = a.coord_lo + a.prod_mid;
    b_next.dvd    = DVD_W'(a.num) * DVD_W'(texture_height);
  end

  assign dsrc[0] = '{column: b.column, row: b.row, region: b.region, mirror: b.mirror,
                     lh: b.lh, frac: b.frac, rem: b.dvd, quo: '0, tx: '0};

  for (genvar g = 1; g < DIV_BITS; g++) begin : g_dsrc
    assign dsrc[g] = dst[g-1];
  end

  // Restoring divider, one quotient bit per stage; the texel column rides along.
  always_comb begin
    logic [DVD_W-1:0] divisor;
    logic [DVD_W-1:0] txp;
    for (int k = 0; k < DIV_BITS; k++) begin
      dst_next[k] = dsrc[k];
      divisor = DVD_W'(dsrc[k].lh) << (DIV_BITS - 1 - k);
      if (dsrc[k].rem >= divisor) begin
        dst_next[k].rem = dsrc[k].rem - divisor;
        dst_next[k].quo[DIV_BITS-1-k] = 1'b1;
      end
      txp = DVD_W'(dsrc[k].frac) * DVD_W'(texture_width);
      if (k == 0) begin
        dst_next[k].tx = txp[DVD_W-1:FRAC_W];
      end else if (k == 1 && dsrc[k].mirror && texture_width != '0) begin
        dst_next[k].tx = texture_width - dsrc[k].tx - CFG_W'(1);
      end
    end
  end

  always_comb begin
    o_next.column = dst[DIV_BITS-1].column;
    o_next.row    = dst[DIV_BITS-1].row;
    o_next.region = dst[DIV_BITS-1].region;
    o_next.fill   = '0;
    o_next.tx     = '0;
    o_next.ty     = '0;
    case (dst[DIV_BITS-1].region)
      REGION_CEILING: o_next.fill = ceiling_rgb;
      REGION_FLOOR:   o_next.fill = floor_rgb;
      REGION_WALL: begin
        o_next.tx = sat_texel(dst[DIV_BITS-1].tx);
        o_next.ty = sat_texel(dst[DIV_BITS-1].quo);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[ST_A]) begin
      a <= a_next;
    end
    if (en[ST_B]) begin
      b <= b_next;
    end
    for (int k = 0; k < DIV_BITS; k++) begin
      if (en[ST_D+k]) begin
        dst[k] <= dst_next[k];
      end
    end
    if (en[ST_O]) begin
      o <= o_next;
    end
  end

  assign texel.valid      = v[ST_O];
  assign texel.out_column = o.column;
  assign texel.out_row    = o.row;
  assign texel.region     = o.region;
  assign texel.fill_rgb   = o.fill;
  assign texel.texel_x    = o.tx;
  assign texel.texel_y    = o.ty;

endmodule

`default_nettype wire

// ===== test/raycast_wall_column_texel_core_tb.sv =====
// Self-checking testbench of the wall column texel core: predicted texel words against the DUT.
`timescale 1ns / 100ps

module raycast_wall_column_texel_core_tb;
  import rwct_pkg::*;

  typedef struct packed {
    logic [COLUMN_W-1:0] column;
    logic [ROW_W-1:0]    row;
    logic [SLICE_W-1:0]  slice_height;
    logic [COORD_W-1:0]  player_coord;
    logic [COORD_W-1:0]  perp_dist;
    logic [DIR_W-1:0]    ray_dir;
    logic                hit_side;
    logic                side_dir_negative;
  } pixel_word_t;

  typedef struct packed {
    logic [COLUMN_W-1:0] column;
    logic [ROW_W-1:0]    row;
    region_t             region;
    logic [RGB_W-1:0]    fill_rgb;
    logic [TEXEL_W-1:0]  texel_x;
    logic [TEXEL_W-1:0]  texel_y;
  } texel_word_t;

  class texel_scoreboard;
    texel_word_t      pending_texels[$];
    int unsigned      failures;
    longint           screen_h;
    longint           tex_w;
    longint           tex_h;
    logic [RGB_W-1:0] ceiling_rgb;
    logic [RGB_W-1:0] floor_rgb;

    function new();
      failures    = 0;
      screen_h    = SCREEN_HEIGHT_RESET;
      tex_w       = TEXTURE_WIDTH_RESET;
      tex_h       = TEXTURE_HEIGHT_RESET;
      ceiling_rgb = '0;
      floor_rgb   = '0;
    endfunction

    function void set_reg(reg_index_t idx, logic [REG_DATA_W-1:0] data);
      case (idx)
        REG_SCREEN_HEIGHT:  screen_h = data[CFG_W-1:0];
        REG_TEXTURE_WIDTH:  tex_w = data[CFG_W-1:0];
        REG_TEXTURE_HEIGHT: tex_h = data[CFG_W-1:0];
        REG_CEILING_RGB:    ceiling_rgb = data[RGB_W-1:0];
        REG_FLOOR_RGB:      floor_rgb = data[RGB_W-1:0];
        default: ;
      endcase
    endfunction

    function void wall_span(input longint lh, output longint top, output longint bottom);
      top = screen_h / 2 - lh / 2;
      if (top < 0) top = 0;
      bottom = lh / 2 + screen_h / 2;
      if (bottom >= screen_h) bottom = screen_h - 1;
    endfunction

    function texel_word_t shade_pixel(pixel_word_t p);
      texel_word_t w;
      longint      lh, top, bottom, r, num, frac, tx, ty, lim;
      logic [63:0] dist64, dir64, prod;
      logic [31:0] hit;
      w        = '0;
      w.column = p.column;
      w.row    = p.row;
      lh       = p.slice_height;
      r        = p.row;
      wall_span(lh, top, bottom);
      if (top > bottom || r >= screen_h) begin
        w.region = REGION_BLANK;
      end else if (r < top) begin
        w.region   = REGION_CEILING;
        w.fill_rgb = ceiling_rgb;
      end else if (r < bottom) begin
        w.region = REGION_WALL;
        // The hit position along the wall is coord + dist * dir in Q16.16.
        dist64 = {32'd0, p.perp_dist};
        dir64  = {{(64-DIR_W){p.ray_dir[DIR_W-1]}}, p.ray_dir};
        prod   = dist64 * dir64;
        hit    = p.player_coord + prod[47:16];
        frac   = hit[FRAC_W-1:0];
        tx     = (frac * tex_w) >> FRAC_W;
        if (p.hit_side == p.side_dir_negative && tex_w != 0) tx = tex_w - tx - 1;
        if (tx > TEXEL_MAX) tx = TEXEL_MAX;
        w.texel_x = TEXEL_W'(tx);
        num = r - screen_h / 2 + lh / 2;
        if (lh <= 0 || num < 0 || tex_h == 0) begin
          ty = 0;
        end else begin
          ty  = num * tex_h / lh;
          lim = tex_h - 1;
          if (lim > TEXEL_MAX) lim = TEXEL_MAX;
          if (ty > lim) ty = lim;
        end
        w.texel_y = TEXEL_W'(ty);
      end else begin
        w.region   = REGION_FLOOR;
        w.fill_rgb = floor_rgb;
      end
      return w;
    endfunction

    function void note_pixel(pixel_word_t p);
      pending_texels.push_back(shade_pixel(p));
    endfunction

    function void report(string what, texel_word_t want, texel_word_t got);
      failures++;
      if (failures <= 10) begin
        $write("%s: want col=%0d row=%0d region=%0d fill=%06h tx=%0d ty=%0d, ",
               what, want.column, want.row, want.region, want.fill_rgb, want.texel_x,
               want.texel_y);
        $display("got col=%0d row=%0d region=%0d fill=%06h tx=%0d ty=%0d",
                 got.column, got.row, got.region, got.fill_rgb, got.texel_x, got.texel_y);
      end
    endfunction

    function void check_texel(texel_word_t got);
      texel_word_t want;
      if (pending_texels.size() == 0) begin
        report("unexpected texel word", '0, got);
      end else begin
        want = pending_texels.pop_front();
        if (got.column !== want.column || got.row !== want.row ||
            got.region !== want.region || got.fill_rgb !== want.fill_rgb ||
            got.texel_x !== want.texel_x || got.texel_y !== want.texel_y)
          report("texel word differs", want, got);
      end
    endfunction

    function void drain();
      while (pending_texels.size() != 0)
        report("texel word never arrived", pending_texels.pop_front(), '0);
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   wr_en;
  logic [REG_INDEX_W-1:0] wr_index;
  logic [REG_DATA_W-1:0]  wr_data;
  bit                     steady;
  texel_scoreboard        sb = new();

  rwct_pixel_if pixel();
  rwct_texel_if texel();

  raycast_wall_column_texel_core i_dut (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .pixel    (pixel),
    .texel    (texel)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #3_000_000;
    $display("raycast_wall_column_texel_core: mismatch");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && pixel.valid && pixel.ready)
      sb.note_pixel('{column: pixel.column, row: pixel.row,
                      slice_height: pixel.slice_height, player_coord: pixel.player_coord,
                      perp_dist: pixel.perp_dist, ray_dir: pixel.ray_dir,
                      hit_side: pixel.hit_side, side_dir_negative: pixel.side_dir_negative});
  end

  always @(posedge clk) begin
    if (!rst && texel.valid && texel.ready)
      sb.check_texel('{column: texel.out_column, row: texel.out_row,
                       region: region_t'(texel.region), fill_rgb: texel.fill_rgb,
                       texel_x: texel.texel_x, texel_y: texel.texel_y});
  end

  initial begin
    int unsigned stall;
    texel.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 15);
      if (stall != 0) begin
        texel.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      texel.ready <= 1'b1;
      do @(posedge clk); while (!(texel.valid && texel.ready));
    end
  end

  task automatic write_reg(reg_index_t idx, logic [REG_DATA_W-1:0] data);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= data;
    @(posedge clk);
    sb.set_reg(idx, data);
  endtask

  task automatic set_config(logic [CFG_W-1:0] h, logic [CFG_W-1:0] tw, logic [CFG_W-1:0] th,
                            logic [RGB_W-1:0] ceiling_c, logic [RGB_W-1:0] floor_c);
    write_reg(REG_SCREEN_HEIGHT, REG_DATA_W'(h));
    write_reg(REG_TEXTURE_WIDTH, REG_DATA_W'(tw));
    write_reg(REG_TEXTURE_HEIGHT, REG_DATA_W'(th));
    write_reg(REG_CEILING_RGB, ceiling_c);
    write_reg(REG_FLOOR_RGB, floor_c);
    wr_en <= 1'b0;
  endtask

  task automatic send_pixel(pixel_word_t p);
    int unsigned gap;
    gap = steady ? 0 : $urandom_range(0, 15);
    if (gap != 0) begin
      pixel.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pixel.column            <= p.column;
    pixel.row               <= p.row;
    pixel.slice_height      <= p.slice_height;
    pixel.player_coord      <= p.player_coord;
    pixel.perp_dist         <= p.perp_dist;
    pixel.ray_dir           <= p.ray_dir;
    pixel.hit_side          <= p.hit_side;
    pixel.side_dir_negative <= p.side_dir_negative;
    pixel.valid             <= 1'b1;
    do @(posedge clk); while (!(pixel.valid && pixel.ready));
  endtask

  task automatic settle();
    pixel.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_texels.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic pixel_word_t pix(int unsigned col, int unsigned row, int unsigned lh,
                                      logic [31:0] coord, logic [31:0] perp,
                                      logic [DIR_W-1:0] dir, bit side, bit neg);
    return '{column: COLUMN_W'(col), row: ROW_W'(row), slice_height: SLICE_W'(lh),
             player_coord: coord, perp_dist: perp, ray_dir: dir, hit_side: side,
             side_dir_negative: neg};
  endfunction

  function automatic logic [CFG_W-1:0] random_dim();
    case ($urandom_range(0, 19))
      0:       return 11'd0;
      1:       return 11'd1;
      2:       return 11'd2;
      3:       return 11'd1024;
      4:       return 11'd2047;
      default: return CFG_W'($urandom_range(1, 1024));
    endcase
  endfunction

  function automatic pixel_word_t random_pixel();
    pixel_word_t p;
    longint      lh, top, bottom, r;
    p.column            = COLUMN_W'($urandom);
    p.player_coord      = $urandom;
    p.perp_dist         = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 32'h000F_FFFF);
    p.ray_dir           = DIR_W'($urandom);
    p.hit_side          = 1'($urandom);
    p.side_dir_negative = 1'($urandom);
    case ($urandom_range(0, 9))
      0:       lh = $urandom_range(0, 65535);
      1:       lh = 65535;
      default: lh = $urandom_range(1, 32'(2 * sb.screen_h + 2));
    endcase
    p.slice_height = SLICE_W'(lh);
    sb.wall_span(p.slice_height, top, bottom);
    case ($urandom_range(0, 7))
      0, 1: r = $urandom_range(0, 1023);
      2: begin
        case ($urandom_range(0, 4))
          0:       r = top - 1;
          1:       r = top;
          2:       r = bottom - 1;
          3:       r = bottom;
          default: r = bottom + 1;
        endcase
      end
      default: r = (bottom > top && top <= 1023) ? $urandom_range(32'(top), 32'(bottom - 1))
                                                 : $urandom_range(0, 1023);
    endcase
    if (r < 0) r = 0;
    if (r > 1023) r = 1023;
    p.row = ROW_W'(r);
    return p;
  endfunction

  task automatic random_run(int unsigned count);
    repeat (count) send_pixel(random_pixel());
  endtask

  initial begin
    rst                     <= 1'b1;
    wr_en                   <= 1'b0;
    wr_index                <= '0;
    wr_data                 <= '0;
    steady                  = 1'b0;
    pixel.valid             <= 1'b0;
    pixel.column            <= '0;
    pixel.row               <= '0;
    pixel.slice_height      <= '0;
    pixel.player_coord      <= '0;
    pixel.perp_dist         <= '0;
    pixel.ray_dir           <= '0;
    pixel.hit_side          <= 1'b0;
    pixel.side_dir_negative <= 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Default geometry: 480 rows, so a slice of 100 spans rows 190 to 289.
    set_config(11'd480, 11'd64, 11'd64, 24'hFFFFFF, 24'h000000);
    send_pixel(pix(0, 0, 100, 32'h0, 32'h0, 18'h0, 0, 0));
    send_pixel(pix(2047, 190, 100, 32'hFFFFFFFF, 32'hFFFFFFFF, 18'h20000, 0, 1));
    send_pixel(pix(1, 289, 100, 32'h0001_8000, 32'h0002_0000, 18'h1FFFF, 1, 0));
    send_pixel(pix(2, 290, 100, 32'h0000_FFFF, 32'h0001_0000, 18'h00001, 1, 1));
    send_pixel(pix(3, 479, 100, 32'h1234_5678, 32'h0, 18'h0, 0, 0));
    send_pixel(pix(4, 480, 100, 32'h0, 32'h0, 18'h0, 0, 0));
    send_pixel(pix(5, 1023, 100, 32'h0, 32'h0, 18'h0, 0, 0));
    send_pixel(pix(6, 0, 65535, 32'h8000_0000, 32'hFFFF_0000, 18'h3FFFF, 0, 0));
    send_pixel(pix(7, 478, 65535, 32'h0000_7FFF, 32'h0, 18'h0, 1, 1));
    send_pixel(pix(8, 479, 65535, 32'h0, 32'h0, 18'h0, 0, 0));
    send_pixel(pix(9, 240, 1, 32'h0, 32'h0, 18'h0, 0, 0));
    send_pixel(pix(10, 240, 0, 32'h0, 32'h0, 18'h0, 0, 0));
    send_pixel(pix(11, 239, 0, 32'h0, 32'h0, 18'h0, 0, 0));
    send_pixel(pix(12, 239, 2, 32'h0000_C000, 32'h0, 18'h0, 0, 1));
    random_run(100);
    settle();

    // With no rows on screen every pixel is blank.
    set_config(11'd0, 11'd1, 11'd1, 24'h000000, 24'hFFFFFF);
    send_pixel(pix(100, 0, 50, 32'h0, 32'h0, 18'h0, 0, 0));
    random_run(40);
    settle();

    // A single row never holds wall; zero texture sizes give zero texels.
    set_config(11'd1, 11'd0, 11'd0, 24'h123456, 24'hABCDEF);
    send_pixel(pix(200, 0, 65535, 32'h0, 32'h0, 18'h0, 0, 0));
    send_pixel(pix(201, 1, 65535, 32'h0, 32'h0, 18'h0, 0, 0));
    random_run(60);
    settle();

    set_config(11'd2, 11'd2047, 11'd2047, 24'h5A5A5A, 24'hA5A5A5);
    send_pixel(pix(300, 0, 2, 32'h0000_FFFF, 32'h0, 18'h0, 1, 0));
    send_pixel(pix(301, 0, 2, 32'h0000_FFFF, 32'h0, 18'h0, 0, 0));
    send_pixel(pix(302, 1, 2, 32'h0, 32'h0, 18'h0, 0, 0));
    random_run(60);
    settle();

    set_config(11'd1024, 11'd1024, 11'd1024, 24'hFF0000, 24'h00FF00);
    send_pixel(pix(400, 1022, 65535, 32'h0000_FFFF, 32'h0, 18'h0, 1, 0));
    send_pixel(pix(401, 1023, 65535, 32'h0, 32'h0, 18'h0, 0, 0));
    random_run(80);
    settle();

    steady = 1'b1;
    set_config(11'd2047, 11'd1, 11'd1024, 24'h0000FF, 24'hFFFF00);
    random_run(60);
    settle();

    repeat (8) begin
      steady = ($urandom_range(0, 3) == 0);
      set_config(random_dim(), random_dim(), random_dim(), RGB_W'($urandom), RGB_W'($urandom));
      random_run(70);
      settle();
    end

    repeat (20) @(posedge clk);
    sb.drain();
    if (sb.failures == 0) begin
      $display("raycast_wall_column_texel_core: match");
    end else begin
      $display("raycast_wall_column_texel_core: mismatch");
    end
    $finish;
  end

endmodule
